// ===== rtl/xyzbad_pkg.sv =====
// Shared constants and types for the xyz block average decimator.
`timescale 1ns / 1ps
package xyzbad_pkg;

  localparam int MAX_BLOCK   = 16;
  localparam int SAMPLE_BITS = 16;
  localparam int TIME_W      = 64;
  localparam int RING_DEPTH  = MAX_BLOCK + 1;
  localparam int PTR_W       = $clog2(RING_DEPTH);
  localparam int CNT_W       = $clog2(MAX_BLOCK + 1);
  localparam int SUM_W       = SAMPLE_BITS + $clog2(RING_DEPTH);
  localparam int USEC_PER_MS = 1000;
  localparam int BSIZE_W     = 5;
  localparam int TMO_W       = 16;
  localparam int LIMIT_W     = TMO_W + $clog2(USEC_PER_MS);
  localparam int CFG_IDX_W   = 8;
  localparam int CFG_DATA_W  = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BUFFER_SIZE = 8'd0,
    CFG_TIMEOUT_MS  = 8'd1
  } cfg_idx_t;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  typedef struct packed {
    logic [TIME_W-1:0] t;
    sample_t           x;
    sample_t           y;
    sample_t           z;
  } ring_entry_t;

endpackage

// ===== rtl/xyzbad_in_if.sv =====
// Input sample channel.
`timescale 1ns / 1ps
interface xyzbad_in_if import xyzbad_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [TIME_W-1:0] sample_time;
  sample_t           sample_x;
  sample_t           sample_y;
  sample_t           sample_z;

  modport source (output valid, sample_time, sample_x, sample_y, sample_z, input ready);
  modport sink   (input valid, sample_time, sample_x, sample_y, sample_z, output ready);
endinterface

// ===== rtl/xyzbad_out_if.sv =====
// Averaged result channel.
`timescale 1ns / 1ps
interface xyzbad_out_if import xyzbad_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [TIME_W-1:0] out_time;
  sample_t           avg_x;
  sample_t           avg_y;
  sample_t           avg_z;

  modport source (output valid, out_time, avg_x, avg_y, avg_z, input ready);
  modport sink   (input valid, out_time, avg_x, avg_y, avg_z, output ready);
endinterface

// ===== rtl/xyzbad_cfg_if.sv =====
// Configuration register write channel.
`timescale 1ns / 1ps
interface xyzbad_cfg_if import xyzbad_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  reg_index;
  logic [CFG_DATA_W-1:0] wdata;

  modport source (output valid, reg_index, wdata, input ready);
  modport sink   (input valid, reg_index, wdata, output ready);
endinterface

// ===== rtl/xyz_block_average_decimator.sv =====
// Boxcar average decimator for timestamped three-axis samples.
// Each accepted sample is written to a 17-entry ring memory and added to
// running sums. The sequencer then reads the oldest entry (registered read)
// and evicts it while more samples are held than the block length
// (buffer_size, with zero taken as one and values above 16 as 16), or while
// timeout_ms is nonzero and the age (64-bit modular difference to the new
// timestamp) exceeds timeout_ms*1000 us. When exactly block-length samples
// remain, three restoring dividers produce the truncated means, the result
// is loaded into the output register and the buffer is cleared.
// Per sample: an accept state, then a read and a check state per oldest-entry
// check, plus the divide states and a load state when a result is produced;
// the load waits while a stalled result still holds the output register.
// The next sample is accepted while a finished result waits in the output
// register. Config writes are taken every cycle; write only while idle.
`timescale 1ns / 1ps
module xyz_block_average_decimator
  import xyzbad_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  xyzbad_in_if.sink         in_ch,
  xyzbad_out_if.source      out_ch,
  xyzbad_cfg_if.sink        cfg_ch
);

  localparam int DCNT_W = $clog2(SUM_W);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_CHK,
    S_DIV,
    S_OUT
  } state_t;

  state_t                   state_r;
  logic [BSIZE_W-1:0]       buffer_size_r;
  logic [TMO_W-1:0]         timeout_ms_r;
  logic [PTR_W-1:0]         oldest_r;
  logic [CNT_W-1:0]         held_r;
  logic signed [SUM_W-1:0]  sum_x_r, sum_y_r, sum_z_r;
  logic [TIME_W-1:0]        now_r;
  logic [LIMIT_W-1:0]       limit_r;
  logic                     tmo_on_r;
  logic [CNT_W-1:0]         len_r;

  // divider lanes
  logic [SUM_W-1:0]         dvd_x_r, dvd_y_r, dvd_z_r;
  logic [CNT_W-1:0]         rem_x_r, rem_y_r, rem_z_r;
  logic                     neg_x_r, neg_y_r, neg_z_r;
  logic [CNT_W-1:0]         divisor_r;
  logic [DCNT_W-1:0]        dcnt_r;

  logic                     out_valid_r;
  logic [TIME_W-1:0]        out_time_r;
  sample_t                  avg_x_r, avg_y_r, avg_z_r;

  // ring memory
  ring_entry_t              ring_mem [RING_DEPTH];
  ring_entry_t              rd_q;
  logic                     mem_we;
  logic [PTR_W-1:0]         mem_waddr;
  ring_entry_t              mem_wdata;
  logic                     mem_re;

  logic                     in_fire;
  logic [CNT_W-1:0]         len;
  logic [PTR_W:0]           pos_sum;
  logic [PTR_W-1:0]         wr_pos;
  logic                     too_many;
  logic                     too_old;
  logic [TIME_W-1:0]        age;
  logic                     slot_free;

  logic [SUM_W-1:0]         dnx_x, dnx_y, dnx_z;
  logic [CNT_W-1:0]         rnx_x, rnx_y, rnx_z;

  function automatic logic [SUM_W-1:0] mag(input logic signed [SUM_W-1:0] v);
    mag = v[SUM_W-1] ? SUM_W'(-v) : SUM_W'(v);
  endfunction

  function automatic sample_t apply_sign(input logic [SUM_W-1:0] q, input logic neg);
    logic [SUM_W-1:0] s;
    s = neg ? SUM_W'(-q) : q;
    apply_sign = s[SAMPLE_BITS-1:0];
  endfunction

  // One restoring divide step: shift in dividend MSB, subtract if it fits.
  function automatic logic [SUM_W+CNT_W-1:0] div_step(input logic [SUM_W-1:0] dvd,
                                                      input logic [CNT_W-1:0] rem,
                                                      input logic [CNT_W-1:0] dsr);
    logic [CNT_W:0] rs;
    logic [CNT_W:0] diff;
    logic           qb;
    rs   = {rem, dvd[SUM_W-1]};
    diff = rs - {1'b0, dsr};
    qb   = (rs >= {1'b0, dsr});
    div_step = {{dvd[SUM_W-2:0], qb}, qb ? diff[CNT_W-1:0] : rs[CNT_W-1:0]};
  endfunction

  always_comb begin
    if (buffer_size_r == '0) begin
      len = CNT_W'(1);
    end else if (int'(buffer_size_r) > MAX_BLOCK) begin
      len = CNT_W'(MAX_BLOCK);
    end else begin
      len = CNT_W'(buffer_size_r);
    end
  end

  assign in_ch.ready  = (state_r == S_IDLE);
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  assign pos_sum = (PTR_W+1)'(oldest_r) + (PTR_W+1)'(held_r);
  assign wr_pos  = (int'(pos_sum) >= RING_DEPTH) ? PTR_W'(int'(pos_sum) - RING_DEPTH)
                                                 : pos_sum[PTR_W-1:0];

  assign mem_we    = in_fire;
  assign mem_waddr = wr_pos;
  assign mem_wdata = '{t: in_ch.sample_time, x: in_ch.sample_x,
                       y: in_ch.sample_y, z: in_ch.sample_z};
  assign mem_re    = (state_r == S_RD);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      ring_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= ring_mem[oldest_r];
    end
  end

  assign age      = now_r - rd_q.t;
  assign too_many = (held_r > len_r);
  assign too_old  = tmo_on_r && (age > TIME_W'(limit_r));
  assign slot_free = !out_valid_r || out_ch.ready;

  assign {dnx_x, rnx_x} = div_step(dvd_x_r, rem_x_r, divisor_r);
  assign {dnx_y, rnx_y} = div_step(dvd_y_r, rem_y_r, divisor_r);
  assign {dnx_z, rnx_z} = div_step(dvd_z_r, rem_z_r, divisor_r);

  assign out_ch.valid    = out_valid_r;
  assign out_ch.out_time = out_time_r;
  assign out_ch.avg_x    = avg_x_r;
  assign out_ch.avg_y    = avg_y_r;
  assign out_ch.avg_z    = avg_z_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      buffer_size_r <= BSIZE_W'(1);
      timeout_ms_r  <= '0;
      oldest_r      <= '0;
      held_r        <= '0;
      sum_x_r       <= '0;
      sum_y_r       <= '0;
      sum_z_r       <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        unique case (cfg_ch.reg_index)
          CFG_BUFFER_SIZE: buffer_size_r <= cfg_ch.wdata[BSIZE_W-1:0];
          CFG_TIMEOUT_MS:  timeout_ms_r  <= cfg_ch.wdata[TMO_W-1:0];
          default: ;
        endcase
      end

      // in S_OUT the load below takes over the output slot
      if (out_valid_r && out_ch.ready && (state_r != S_OUT)) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            sum_x_r  <= sum_x_r + SUM_W'(in_ch.sample_x);
            sum_y_r  <= sum_y_r + SUM_W'(in_ch.sample_y);
            sum_z_r  <= sum_z_r + SUM_W'(in_ch.sample_z);
            held_r   <= held_r + CNT_W'(1);
            now_r    <= in_ch.sample_time;
            limit_r  <= LIMIT_W'(timeout_ms_r) * LIMIT_W'(USEC_PER_MS);
            tmo_on_r <= (timeout_ms_r != '0);
            len_r    <= len;
            state_r  <= S_RD;
          end
        end
        S_RD: begin
          state_r <= S_CHK;
        end
        S_CHK: begin
          if ((held_r != '0) && (too_many || too_old)) begin
            sum_x_r  <= sum_x_r - SUM_W'(rd_q.x);
            sum_y_r  <= sum_y_r - SUM_W'(rd_q.y);
            sum_z_r  <= sum_z_r - SUM_W'(rd_q.z);
            oldest_r <= (int'(oldest_r) == RING_DEPTH - 1) ? '0 : oldest_r + PTR_W'(1);
            held_r   <= held_r - CNT_W'(1);
            state_r  <= S_RD;
          end else if (held_r < len_r) begin
            state_r <= S_IDLE;
          end else begin
            dvd_x_r   <= mag(sum_x_r);
            dvd_y_r   <= mag(sum_y_r);
            dvd_z_r   <= mag(sum_z_r);
            neg_x_r   <= sum_x_r[SUM_W-1];
            neg_y_r   <= sum_y_r[SUM_W-1];
            neg_z_r   <= sum_z_r[SUM_W-1];
            rem_x_r   <= '0;
            rem_y_r   <= '0;
            rem_z_r   <= '0;
            divisor_r <= held_r;
            dcnt_r    <= DCNT_W'(SUM_W - 1);
            state_r   <= S_DIV;
          end
        end
        S_DIV: begin
          dvd_x_r <= dnx_x;
          dvd_y_r <= dnx_y;
          dvd_z_r <= dnx_z;
          rem_x_r <= rnx_x;
          rem_y_r <= rnx_y;
          rem_z_r <= rnx_z;
          dcnt_r  <= dcnt_r - DCNT_W'(1);
          if (dcnt_r == '0) begin
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          // dvd_*_r now hold the quotient magnitudes
          if (slot_free) begin
            out_valid_r <= 1'b1;
            out_time_r  <= now_r;
            avg_x_r     <= apply_sign(dvd_x_r, neg_x_r);
            avg_y_r     <= apply_sign(dvd_y_r, neg_y_r);
            avg_z_r     <= apply_sign(dvd_z_r, neg_z_r);
            oldest_r    <= '0;
            held_r      <= '0;
            sum_x_r     <= '0;
            sum_y_r     <= '0;
            sum_z_r     <= '0;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== bench/tb.sv =====
// Self-checking bench for the xyz block average decimator: directed table plus random phases.
`timescale 1ns / 1ps
module tb;
  import xyzbad_pkg::*;

  localparam int PHASES          = 30;
  localparam int ITEMS_PER_PHASE = 55;
  localparam int SETTLE_CYCLES   = 80;   // above the worst per-sample latency
  localparam int HOLD_CYCLES     = 300;
  localparam int DIR_ROWS        = 32;

  localparam logic [CFG_IDX_W-1:0] UNMAPPED_IDX_A = 8'h02;
  localparam logic [CFG_IDX_W-1:0] UNMAPPED_IDX_B = 8'hFF;

  localparam logic [TIME_W-1:0] TMAX   = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [TIME_W-1:0] T_ALT5 = 64'h5555_5555_5555_5555;
  localparam logic [TIME_W-1:0] T_ALTA = 64'hAAAA_AAAA_AAAA_AAAA;
  localparam sample_t PMAX = 16'sh7FFF;
  localparam sample_t PMIN = 16'sh8000;
  localparam sample_t PALT5 = 16'sh5555;
  localparam sample_t PALTA = 16'shAAAA;
  localparam sample_t NEG1 = 16'shFFFF;

  typedef struct packed {
    logic [TIME_W-1:0] t;
    sample_t           x;
    sample_t           y;
    sample_t           z;
  } avg_result_t;

  typedef enum bit {ROW_CFG, ROW_SMP} row_kind_t;

  typedef struct packed {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    logic [TIME_W-1:0]     t;
    sample_t               x;
    sample_t               y;
    sample_t               z;
    bit                    typed;
    avg_result_t           want;
  } stim_row_t;

  localparam avg_result_t NO_RES = '0;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  xyzbad_in_if  in_if ();
  xyzbad_out_if out_if ();
  xyzbad_cfg_if cfg_if ();

  xyz_block_average_decimator uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Predictor state: sample history ring, running sums, register copies.
  logic [TIME_W-1:0] hist_t [RING_DEPTH];
  int                hist_x [RING_DEPTH];
  int                hist_y [RING_DEPTH];
  int                hist_z [RING_DEPTH];
  int                oldest_idx = 0;
  int                held_cnt = 0;
  int                acc_x = 0;
  int                acc_y = 0;
  int                acc_z = 0;
  logic [BSIZE_W-1:0] model_bsize = 5'd1;
  logic [TMO_W-1:0]   model_tmo = '0;

  avg_result_t avg_expected_q [$];
  avg_result_t head_result;
  int          mismatch_count = 0;
  bit          no_idle = 1'b0;
  bit          hold_rx = 1'b0;

  stim_row_t directed_rows [DIR_ROWS] = '{
    '{ROW_SMP, 8'h00, 16'h0000, 64'd0, PMAX, PMIN, 16'sd0, 1'b1, '{64'd0, PMAX, PMIN, 16'sd0}},
    '{ROW_SMP, 8'h00, 16'h0000, TMAX, PMIN, PMAX, NEG1, 1'b1, '{TMAX, PMIN, PMAX, NEG1}},
    '{ROW_SMP, 8'h00, 16'h0000, T_ALT5, PALT5, PALTA, 16'sd1, 1'b1,
      '{T_ALT5, PALT5, PALTA, 16'sd1}},
    '{ROW_SMP, 8'h00, 16'h0000, T_ALTA, PALTA, PALT5, NEG1, 1'b1,
      '{T_ALTA, PALTA, PALT5, NEG1}},
    // size zero behaves as one
    '{ROW_CFG, CFG_BUFFER_SIZE, 16'h0000, 64'd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, NO_RES},
    '{ROW_SMP, 8'h00, 16'h0000, 64'd10, NEG1, 16'sd0, PMAX, 1'b1, '{64'd10, NEG1, 16'sd0, PMAX}},
    '{ROW_CFG, UNMAPPED_IDX_A, 16'hFFFF, 64'd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, NO_RES},
    '{ROW_CFG, UNMAPPED_IDX_B, 16'h0003, 64'd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, NO_RES},
    '{ROW_SMP, 8'h00, 16'h0000, 64'd11, 16'sd1, 16'sd2, 16'sd3, 1'b1,
      '{64'd11, 16'sd1, 16'sd2, 16'sd3}},
    '{ROW_CFG, CFG_BUFFER_SIZE, 16'h0002, 64'd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, NO_RES},
    '{ROW_SMP, 8'h00, 16'h0000, 64'd100, PMAX, PMIN, 16'sd1, 1'b0, NO_RES},
    // -1/2 truncates to zero
    '{ROW_SMP, 8'h00, 16'h0000, 64'd200, PMAX, PMIN, -16'sd2, 1'b1,
      '{64'd200, PMAX, PMIN, 16'sd0}},
    // above the maximum: clamps to sixteen
    '{ROW_CFG, CFG_BUFFER_SIZE, 16'h001F, 64'd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, NO_RES},
    '{ROW_SMP, 8'h00, 16'h0000, 64'd300, 16'sd5, 16'sd5, 16'sd5, 1'b0, NO_RES},
    '{ROW_CFG, CFG_BUFFER_SIZE, 16'h0004, 64'd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, NO_RES},
    '{ROW_SMP, 8'h00, 16'h0000, 64'd1000, 16'sd10, 16'sd20, 16'sd30, 1'b0, NO_RES},
    '{ROW_SMP, 8'h00, 16'h0000, 64'd2000, -16'sd10, -16'sd20, -16'sd30, 1'b0, NO_RES},
    // shrink while three samples are held: next sample evicts down to itself
    '{ROW_CFG, CFG_BUFFER_SIZE, 16'h0001, 64'd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, NO_RES},
    '{ROW_SMP, 8'h00, 16'h0000, 64'd3000, 16'sd7, -16'sd7, 16'sd0, 1'b1,
      '{64'd3000, 16'sd7, -16'sd7, 16'sd0}},
    '{ROW_CFG, CFG_BUFFER_SIZE, 16'h0003, 64'd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, NO_RES},
    '{ROW_CFG, CFG_TIMEOUT_MS, 16'h0001, 64'd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, NO_RES},
    '{ROW_SMP, 8'h00, 16'h0000, 64'd10000, 16'sd1, 16'sd1, 16'sd1, 1'b0, NO_RES},
    '{ROW_SMP, 8'h00, 16'h0000, 64'd10500, 16'sd2, 16'sd2, 16'sd2, 1'b0, NO_RES},
    // both older samples age out, the newest stays
    '{ROW_SMP, 8'h00, 16'h0000, 64'd12000, 16'sd3, 16'sd3, 16'sd3, 1'b0, NO_RES},
    '{ROW_SMP, 8'h00, 16'h0000, 64'd12400, 16'sd4, 16'sd4, 16'sd4, 1'b0, NO_RES},
    // timestamp goes backward: wrapped age looks huge
    '{ROW_SMP, 8'h00, 16'h0000, 64'd5, -16'sd3, -16'sd3, -16'sd3, 1'b0, NO_RES},
    '{ROW_CFG, CFG_TIMEOUT_MS, 16'h0000, 64'd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, NO_RES},
    '{ROW_SMP, 8'h00, 16'h0000, 64'd6, 16'sd4, 16'sd4, 16'sd4, 1'b0, NO_RES},
    '{ROW_SMP, 8'h00, 16'h0000, 64'd7, 16'sd1, 16'sd1, 16'sd1, 1'b0, NO_RES},
    '{ROW_CFG, CFG_TIMEOUT_MS, 16'hFFFF, 64'd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, NO_RES},
    // upper data bits are dropped: size one
    '{ROW_CFG, CFG_BUFFER_SIZE, 16'hFFE1, 64'd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, NO_RES},
    '{ROW_SMP, 8'h00, 16'h0000, TMAX, PMIN, PMIN, PMIN, 1'b1, '{TMAX, PMIN, PMIN, PMIN}}
  };

  function automatic bit predict_average(input logic [TIME_W-1:0] t, input sample_t x,
                                         input sample_t y, input sample_t z,
                                         output avg_result_t res);
    int                len;
    int                pos;
    logic [TIME_W-1:0] age_limit;
    bit                too_many;
    bit                too_old;
    bit                evicting;
    len = (model_bsize == 0) ? 1 : ((model_bsize > MAX_BLOCK) ? MAX_BLOCK : int'(model_bsize));
    age_limit = 64'(model_tmo) * 64'(USEC_PER_MS);
    pos = (oldest_idx + held_cnt) % RING_DEPTH;
    hist_t[pos] = t;
    hist_x[pos] = x;
    hist_y[pos] = y;
    hist_z[pos] = z;
    acc_x += x;
    acc_y += y;
    acc_z += z;
    held_cnt++;
    evicting = 1'b1;
    while (evicting && held_cnt > 0) begin
      too_many = held_cnt > len;
      too_old = (model_tmo != 0) && ((t - hist_t[oldest_idx]) > age_limit);
      if (too_many || too_old) begin
        acc_x -= hist_x[oldest_idx];
        acc_y -= hist_y[oldest_idx];
        acc_z -= hist_z[oldest_idx];
        oldest_idx = (oldest_idx + 1) % RING_DEPTH;
        held_cnt--;
      end else begin
        evicting = 1'b0;
      end
    end
    res = '0;
    if (held_cnt < len) return 1'b0;
    res.t = t;
    res.x = SAMPLE_BITS'(acc_x / held_cnt);
    res.y = SAMPLE_BITS'(acc_y / held_cnt);
    res.z = SAMPLE_BITS'(acc_z / held_cnt);
    oldest_idx = 0;
    held_cnt = 0;
    acc_x = 0;
    acc_y = 0;
    acc_z = 0;
    return 1'b1;
  endfunction

  function automatic int draw_gap();
    return no_idle ? 0 : $urandom_range(0, 5);
  endfunction

  function automatic sample_t rand_sample();
    int r;
    r = $urandom_range(0, 7);
    if (r == 0) return PMAX;
    if (r == 1) return PMIN;
    return sample_t'($urandom);
  endfunction

  // Drop valid, wait for outstanding averages, then let a silent sample finish.
  task automatic settle_block();
    in_if.valid <= 1'b0;
    while (avg_expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic pause_for_results();
    in_if.valid <= 1'b0;
    do @(posedge clk); while (avg_expected_q.size() != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    settle_block();
    cfg_if.reg_index <= idx;
    cfg_if.wdata     <= data;
    cfg_if.valid     <= 1'b1;
    do @(posedge clk); while (!(cfg_if.valid && cfg_if.ready));
    case (idx)
      CFG_BUFFER_SIZE: model_bsize = data[BSIZE_W-1:0];
      CFG_TIMEOUT_MS:  model_tmo = data[TMO_W-1:0];
      default: ;
    endcase
    cfg_if.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_sample(input logic [TIME_W-1:0] t, input sample_t x, input sample_t y,
                             input sample_t z, input bit typed, input avg_result_t want);
    int          k;
    bit          has_res;
    avg_result_t res;
    k = draw_gap();
    if (k > 0) begin
      in_if.valid <= 1'b0;
      repeat (k) @(posedge clk);
    end
    in_if.sample_time <= t;
    in_if.sample_x    <= x;
    in_if.sample_y    <= y;
    in_if.sample_z    <= z;
    in_if.valid       <= 1'b1;
    do @(posedge clk); while (!(in_if.valid && in_if.ready));
    has_res = predict_average(t, x, y, z, res);
    if (typed) avg_expected_q = {avg_expected_q, want};
    else if (has_res) avg_expected_q = {avg_expected_q, res};
  endtask

  task automatic report_field(input string name, input logic [TIME_W-1:0] want,
                              input logic [TIME_W-1:0] got);
    $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    mismatch_count++;
  endtask

  // Result side: random stalls, one long hold-off on request.
  initial begin
    int k;
    out_if.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      k = hold_rx ? HOLD_CYCLES : draw_gap();
      hold_rx = 1'b0;
      if (k > 0) begin
        out_if.ready <= 1'b0;
        repeat (k) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (!(out_if.valid && out_if.ready));
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      if (avg_expected_q.size() == 0) begin
        $display("%0t ns: average with none expected, actual t=%0h x=%0h y=%0h z=%0h",
                 $time, out_if.out_time, out_if.avg_x, out_if.avg_y, out_if.avg_z);
        mismatch_count++;
      end else begin
        head_result = avg_expected_q.pop_front();
        if (out_if.out_time !== head_result.t) report_field("out_time", head_result.t,
                                                            out_if.out_time);
        if (out_if.avg_x !== head_result.x) report_field("avg_x", head_result.x, out_if.avg_x);
        if (out_if.avg_y !== head_result.y) report_field("avg_y", head_result.y, out_if.avg_y);
        if (out_if.avg_z !== head_result.z) report_field("avg_z", head_result.z, out_if.avg_z);
      end
    end
  end

  initial begin
    #40_000_000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    int                   ph;
    int                   i;
    int                   r;
    logic [BSIZE_W-1:0]   bs;
    logic [TMO_W-1:0]     tm;
    logic [CFG_DATA_W-1:0] wd;
    logic [TIME_W-1:0]    now_t;
    int unsigned          step_max;
    stim_row_t            row;

    in_if.valid       = 1'b0;
    in_if.sample_time = '0;
    in_if.sample_x    = '0;
    in_if.sample_y    = '0;
    in_if.sample_z    = '0;
    cfg_if.valid      = 1'b0;
    cfg_if.reg_index  = '0;
    cfg_if.wdata      = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (i = 0; i < DIR_ROWS; i++) begin
      row = directed_rows[i];
      if (row.kind == ROW_CFG) write_reg(row.idx, row.data);
      else send_sample(row.t, row.x, row.y, row.z, row.typed, row.want);
    end

    now_t = {$urandom, $urandom};
    for (ph = 0; ph < PHASES; ph++) begin
      if (ph == 0) begin
        bs = 5'd1;
        tm = '0;
      end else begin
        r = $urandom_range(0, 9);
        case (r)
          0:       bs = 5'd1;
          1:       bs = 5'd16;
          2:       bs = 5'd0;
          3:       bs = 5'($urandom_range(17, 31));
          default: bs = 5'($urandom_range(2, 6));
        endcase
        r = $urandom_range(0, 9);
        case (r)
          0, 1, 2: tm = '0;
          3:       tm = 16'd1;
          7:       tm = 16'hFFFF;
          8:       tm = 16'($urandom);
          default: tm = 16'($urandom_range(1, 8));
        endcase
      end
      wd = 16'($urandom);
      wd[BSIZE_W-1:0] = bs;
      write_reg(CFG_BUFFER_SIZE, wd);
      write_reg(CFG_TIMEOUT_MS, tm);
      if ($urandom_range(0, 5) == 0)
        write_reg(($urandom_range(0, 1) == 0) ? UNMAPPED_IDX_A : UNMAPPED_IDX_B, 16'($urandom));

      no_idle = (ph == 0) || ($urandom_range(0, 4) == 0);
      // long result stall while samples keep coming fills the block
      if (ph == 0 || $urandom_range(0, 9) == 0) hold_rx = 1'b1;
      if ($urandom_range(0, 3) == 0) now_t = {$urandom, $urandom};
      if (tm == 0) step_max = $urandom_range(1, 100000);
      else if (tm <= 8) step_max = 700 * tm;
      else step_max = $urandom;

      for (i = 0; i < ITEMS_PER_PHASE; i++) begin
        r = $urandom_range(0, 39);
        if (r == 0) now_t = now_t - $urandom_range(1, 1000000);
        else if (r != 1) now_t = now_t + $urandom_range(0, step_max);
        send_sample(now_t, rand_sample(), rand_sample(), rand_sample(), 1'b0, NO_RES);
        if ($urandom_range(0, 59) == 0) pause_for_results();
      end
    end

    settle_block();
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
